>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, ignored while reset is high
`define FRWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition in one cycle implies consequence in the next cycle
`define FRWS_ASSERT_NEXT(label, ante, cons, msg) \
   `FRWS_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> src/frws_pkg.sv
// shared constants and types of the frame rate window statistics block
package frws_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int TS_W         = 32;
   localparam int IV_W         = 20;
   localparam int FPS_W        = 28;
   localparam int SUM_W        = IV_W + IDX_W;

   // shared divider: dividend wide enough for the window sum and the fps scale
   localparam int DIV_NW    = (SUM_W > FPS_W) ? SUM_W : FPS_W;
   localparam int DIV_STEPS = (DIV_NW + 1) / 2;
   localparam int DIV_QW    = 2 * DIV_STEPS;
   localparam int DIV_DW    = (IV_W > CNT_W) ? IV_W : CNT_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [FPS_W-1:0] FPS_SCALE    = 28'd256000000;
   localparam logic [IV_W-1:0]  MIN_IV_RESET = 20'd1000;
   localparam logic [IV_W-1:0]  MAX_IV_RESET = 20'd1000000;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_MIN = 1'b0;
   localparam logic CSR_IDX_MAX = 1'b1;

   typedef enum logic [2:0] {
      DSEL_AVG,
      DSEL_CUR,
      DSEL_AFPS,
      DSEL_MIN,
      DSEL_MAX
   } div_sel_type;

   typedef struct packed {
      logic        take;
      logic        rd_old;
      logic        wr_win;
      logic        walk_start;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_en;
      div_sel_type cap_sel;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic div_done;
      logic walk_done;
      logic out_busy;
   } status_type;

endpackage

>>> src/frws_ifs.sv
// item channel interfaces of the frame rate window statistics block
interface frws_req_if;
   logic                          valid;
   logic                          ready;
   logic [frws_pkg::TS_W-1:0]     timestamp_us;

   modport source (output valid, output timestamp_us, input ready);
   modport sink   (input valid, input timestamp_us, output ready);
endinterface

interface frws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [frws_pkg::IV_W-1:0]     frame_time_us;
   logic [frws_pkg::FPS_W-1:0]    current_fps;
   logic [frws_pkg::IV_W-1:0]     average_frame_time_us;
   logic [frws_pkg::FPS_W-1:0]    average_fps;
   logic [frws_pkg::FPS_W-1:0]    min_fps;
   logic [frws_pkg::FPS_W-1:0]    max_fps;
   logic [frws_pkg::CNT_W-1:0]    sample_count;

   modport source (output valid, output frame_time_us, output current_fps,
                   output average_frame_time_us, output average_fps,
                   output min_fps, output max_fps, output sample_count,
                   input ready);
   modport sink   (input valid, input frame_time_us, input current_fps,
                   input average_frame_time_us, input average_fps,
                   input min_fps, input max_fps, input sample_count,
                   output ready);
endinterface

>>> src/frame_rate_window_stats.sv
// top level of the frame rate window statistics block
// Frame rate window statistics: each input item is one frame event with a
// 32-bit microsecond timestamp. The first event after reset only primes the
// stored timestamp; every later one forms the interval to the previous event
// (modulo 2^32) and stores its own timestamp. An interval inside the inclusive
// bounds held in register 0 (min_interval_us, byte address 0) and register 1
// (max_interval_us, byte address 4) enters a 64-entry circular window and
// gives one result item: the interval, its fps, the window average interval
// and its fps, and the min and max fps over the window, all fps values in
// 1/256 fps units with truncating division, plus the entry count. Priming
// events and rejected intervals give no item. For an accepted interval the
// window walk reads one entry a cycle through the memory read port while
// the shared divider works out the average, current fps and average fps,
// then the divider finishes min and max fps. One item is in work at a time;
// a finished result waits in the output register while the next item is
// taken.
module frame_rate_window_stats (
   input  logic                          clock,
   input  logic                          reset,
   frws_req_if.sink                      req_ch,
   frws_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [frws_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [frws_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [frws_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   frws_pkg::cmd_type         cmd;
   frws_pkg::status_type      status;
   logic [frws_pkg::IV_W-1:0] min_iv;
   logic [frws_pkg::IV_W-1:0] max_iv;
   logic                      req_ready;

   frws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .min_iv      (min_iv),
      .max_iv      (max_iv)
   );

   frws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   frws_dp u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .timestamp_us              (req_ch.timestamp_us),
      .min_iv                    (min_iv),
      .max_iv                    (max_iv),
      .rsp_valid                 (rsp_ch.valid),
      .rsp_ready                 (rsp_ch.ready),
      .rsp_frame_time_us         (rsp_ch.frame_time_us),
      .rsp_current_fps           (rsp_ch.current_fps),
      .rsp_average_frame_time_us (rsp_ch.average_frame_time_us),
      .rsp_average_fps           (rsp_ch.average_fps),
      .rsp_min_fps               (rsp_ch.min_fps),
      .rsp_max_fps               (rsp_ch.max_fps),
      .rsp_sample_count          (rsp_ch.sample_count)
   );

endmodule

>>> src/frws_csr.sv
// configuration registers behind the apb-style port
module frws_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [frws_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [frws_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [frws_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [frws_pkg::IV_W-1:0]     min_iv,
   output logic [frws_pkg::IV_W-1:0]     max_iv
);

   logic [frws_pkg::IV_W-1:0] min_iv_ff, min_iv_in;
   logic [frws_pkg::IV_W-1:0] max_iv_ff, max_iv_in;
   logic                      wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      min_iv_in = min_iv_ff;
      max_iv_in = max_iv_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            frws_pkg::CSR_IDX_MIN: min_iv_in = csr_pwdata[frws_pkg::IV_W-1:0];
            frws_pkg::CSR_IDX_MAX: max_iv_in = csr_pwdata[frws_pkg::IV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         frws_pkg::CSR_IDX_MIN:
            csr_prdata = frws_pkg::CSR_DW'(min_iv_ff);
         frws_pkg::CSR_IDX_MAX:
            csr_prdata = frws_pkg::CSR_DW'(max_iv_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_iv_ff <= frws_pkg::MIN_IV_RESET;
         max_iv_ff <= frws_pkg::MAX_IV_RESET;
      end else begin
         min_iv_ff <= min_iv_in;
         max_iv_ff <= max_iv_in;
      end
   end

   assign min_iv = min_iv_ff;
   assign max_iv = max_iv_ff;

endmodule

>>> src/frws_div.sv
// shared radix-4 restoring divider, two quotient bits per cycle
module frws_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [frws_pkg::DIV_QW-1:0]   dividend,
   input  logic [frws_pkg::DIV_DW-1:0]   divisor,
   output logic                          done,
   output logic [frws_pkg::DIV_QW-1:0]   quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [frws_pkg::DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [frws_pkg::DIV_QW-1:0]   quo_ff, quo_in;
   logic [frws_pkg::DIV_DW-1:0]   rem_ff, rem_in;
   logic [frws_pkg::DIV_DW-1:0]   dvs_ff, dvs_in;
   logic                          zero_ff, zero_in;

   logic [frws_pkg::DIV_DW:0]     dvs_ext;
   logic [frws_pkg::DIV_DW:0]     t1, t2, d1, d2;
   logic [frws_pkg::DIV_DW-1:0]   r1, r2;
   logic                          b1, b2;

   always_comb begin
      dvs_ext = {1'b0, dvs_ff};
      t1      = {rem_ff, quo_ff[frws_pkg::DIV_QW-1]};
      d1      = t1 - dvs_ext;
      b1      = t1 >= dvs_ext;
      r1      = b1 ? d1[frws_pkg::DIV_DW-1:0] : t1[frws_pkg::DIV_DW-1:0];
      t2      = {r1, quo_ff[frws_pkg::DIV_QW-2]};
      d2      = t2 - dvs_ext;
      b2      = t2 >= dvs_ext;
      r2      = b2 ? d2[frws_pkg::DIV_DW-1:0] : t2[frws_pkg::DIV_DW-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = frws_pkg::DIV_CW'(frws_pkg::DIV_STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         zero_in = divisor == '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[frws_pkg::DIV_QW-3:0], b1, b2};
         rem_in = r2;
         cnt_in = cnt_ff - frws_pkg::DIV_CW'(1);
         if (cnt_ff == frws_pkg::DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      zero_ff <= zero_in;
   end

   // a zero divisor gives a zero quotient
   assign quotient = zero_ff ? '0 : quo_ff;
   assign done     = done_ff;

endmodule

>>> src/frws_dp.sv
// datapath: timestamp, window memory, window walk, divider operands, result register
module frws_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  frws_pkg::cmd_type             cmd,
   output frws_pkg::status_type          status,
   input  logic [frws_pkg::TS_W-1:0]     timestamp_us,
   input  logic [frws_pkg::IV_W-1:0]     min_iv,
   input  logic [frws_pkg::IV_W-1:0]     max_iv,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [frws_pkg::IV_W-1:0]     rsp_frame_time_us,
   output logic [frws_pkg::FPS_W-1:0]    rsp_current_fps,
   output logic [frws_pkg::IV_W-1:0]     rsp_average_frame_time_us,
   output logic [frws_pkg::FPS_W-1:0]    rsp_average_fps,
   output logic [frws_pkg::FPS_W-1:0]    rsp_min_fps,
   output logic [frws_pkg::FPS_W-1:0]    rsp_max_fps,
   output logic [frws_pkg::CNT_W-1:0]    rsp_sample_count
);

   // timestamp and interval
   logic [frws_pkg::TS_W-1:0]   last_ts_ff;
   logic                        has_prev_ff;
   logic                        keep_ff;
   logic [frws_pkg::IV_W-1:0]   iv_ff;
   logic [frws_pkg::TS_W-1:0]   iv_full;
   logic                        in_range;

   // window
   logic [frws_pkg::IV_W-1:0]   window_mem [frws_pkg::WINDOW_DEPTH];
   logic [frws_pkg::IV_W-1:0]   rd_data_ff;
   logic [frws_pkg::IDX_W-1:0]  rd_addr;
   logic                        rd_en;
   logic [frws_pkg::IDX_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [frws_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [frws_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                        full;

   // walk over the filled entries
   logic                        issue_ff, issue_in;
   logic [frws_pkg::CNT_W-1:0]  walk_cnt_ff, walk_cnt_in;
   logic                        rv_ff, rfirst_ff, rlast_ff;
   logic                        walk_done_ff, walk_done_in;
   logic [frws_pkg::IV_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic                        issue_last;

   // divider and captured results
   logic [frws_pkg::DIV_QW-1:0] div_dividend;
   logic [frws_pkg::DIV_DW-1:0] div_divisor;
   logic                        div_done;
   logic [frws_pkg::DIV_QW-1:0] div_quotient;
   logic [frws_pkg::IV_W-1:0]   avg_ff;
   logic [frws_pkg::FPS_W-1:0]  cur_fps_ff, avg_fps_ff, min_fps_ff, max_fps_ff;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic [frws_pkg::IV_W-1:0]   o_ft_ff, o_aft_ff;
   logic [frws_pkg::FPS_W-1:0]  o_cur_ff, o_afps_ff, o_min_ff, o_max_ff;
   logic [frws_pkg::CNT_W-1:0]  o_cnt_ff;

   // ---------------------------------------------------------------- intake
   assign iv_full  = timestamp_us - last_ts_ff;
   assign in_range = (iv_full >= frws_pkg::TS_W'(min_iv)) &&
                     (iv_full <= frws_pkg::TS_W'(max_iv));

   always_ff @(posedge clock) begin
      if (reset) begin
         has_prev_ff <= 1'b0;
         keep_ff     <= 1'b0;
      end else if (cmd.take) begin
         has_prev_ff <= 1'b1;
         keep_ff     <= has_prev_ff && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         last_ts_ff <= timestamp_us;
         iv_ff      <= iv_full[frws_pkg::IV_W-1:0];
      end
   end

   // ---------------------------------------------------------------- window
   assign full    = fill_ff == frws_pkg::CNT_W'(frws_pkg::WINDOW_DEPTH);
   assign rd_addr = cmd.rd_old ? wr_pos_ff : walk_cnt_ff[frws_pkg::IDX_W-1:0];
   assign rd_en   = cmd.rd_old || issue_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_win) begin
         window_mem[wr_pos_ff] <= iv_ff;
      end
      if (rd_en) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   always_comb begin
      wr_pos_in = wr_pos_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      if (cmd.wr_win) begin
         // when full the oldest entry, read in the previous cycle, leaves the sum
         if (full) begin
            sum_in = sum_ff - frws_pkg::SUM_W'(rd_data_ff) + frws_pkg::SUM_W'(iv_ff);
         end else begin
            sum_in  = sum_ff + frws_pkg::SUM_W'(iv_ff);
            fill_in = fill_ff + frws_pkg::CNT_W'(1);
         end
         if (wr_pos_ff == frws_pkg::IDX_W'(frws_pkg::WINDOW_DEPTH - 1)) begin
            wr_pos_in = '0;
         end else begin
            wr_pos_in = wr_pos_ff + frws_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         wr_pos_ff <= wr_pos_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
      end
   end

   // ---------------------------------------------------------------- walk
   assign issue_last = walk_cnt_ff == (fill_ff - frws_pkg::CNT_W'(1));

   always_comb begin
      issue_in     = issue_ff;
      walk_cnt_in  = walk_cnt_ff;
      walk_done_in = walk_done_ff;
      if (cmd.walk_start) begin
         issue_in     = 1'b1;
         walk_cnt_in  = '0;
         walk_done_in = 1'b0;
      end else begin
         if (issue_ff) begin
            walk_cnt_in = walk_cnt_ff + frws_pkg::CNT_W'(1);
            if (issue_last) begin
               issue_in = 1'b0;
            end
         end
         if (rv_ff && rlast_ff) begin
            walk_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (rv_ff) begin
         if (rfirst_ff || rd_data_ff < lo_ff) begin
            lo_in = rd_data_ff;
         end
         if (rfirst_ff || rd_data_ff > hi_ff) begin
            hi_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         walk_cnt_ff  <= '0;
         walk_done_ff <= 1'b0;
         rv_ff        <= 1'b0;
         rfirst_ff    <= 1'b0;
         rlast_ff     <= 1'b0;
      end else begin
         issue_ff     <= issue_in;
         walk_cnt_ff  <= walk_cnt_in;
         walk_done_ff <= walk_done_in;
         rv_ff        <= issue_ff;
         rfirst_ff    <= issue_ff && (walk_cnt_ff == '0);
         rlast_ff     <= issue_ff && issue_last;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // ---------------------------------------------------------------- divisions
   always_comb begin
      case (cmd.div_sel)
         frws_pkg::DSEL_AVG: begin
            div_dividend = frws_pkg::DIV_QW'(sum_ff);
            div_divisor  = frws_pkg::DIV_DW'(fill_ff);
         end
         frws_pkg::DSEL_CUR: begin
            div_dividend = frws_pkg::DIV_QW'(frws_pkg::FPS_SCALE);
            div_divisor  = frws_pkg::DIV_DW'(iv_ff);
         end
         frws_pkg::DSEL_AFPS: begin
            div_dividend = frws_pkg::DIV_QW'(frws_pkg::FPS_SCALE);
            div_divisor  = frws_pkg::DIV_DW'(avg_ff);
         end
         frws_pkg::DSEL_MIN: begin
            div_dividend = frws_pkg::DIV_QW'(frws_pkg::FPS_SCALE);
            div_divisor  = frws_pkg::DIV_DW'(hi_ff);
         end
         frws_pkg::DSEL_MAX: begin
            div_dividend = frws_pkg::DIV_QW'(frws_pkg::FPS_SCALE);
            div_divisor  = frws_pkg::DIV_DW'(lo_ff);
         end
         default: begin
            div_dividend = frws_pkg::DIV_QW'(frws_pkg::FPS_SCALE);
            div_divisor  = frws_pkg::DIV_DW'(iv_ff);
         end
      endcase
   end

   frws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         case (cmd.cap_sel)
            frws_pkg::DSEL_AVG:  avg_ff     <= div_quotient[frws_pkg::IV_W-1:0];
            frws_pkg::DSEL_CUR:  cur_fps_ff <= div_quotient[frws_pkg::FPS_W-1:0];
            frws_pkg::DSEL_AFPS: avg_fps_ff <= div_quotient[frws_pkg::FPS_W-1:0];
            frws_pkg::DSEL_MIN:  min_fps_ff <= div_quotient[frws_pkg::FPS_W-1:0];
            frws_pkg::DSEL_MAX:  max_fps_ff <= div_quotient[frws_pkg::FPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_ft_ff   <= iv_ff;
         o_cur_ff  <= cur_fps_ff;
         o_aft_ff  <= avg_ff;
         o_afps_ff <= avg_fps_ff;
         o_min_ff  <= min_fps_ff;
         o_max_ff  <= max_fps_ff;
         o_cnt_ff  <= fill_ff;
      end
   end

   assign rsp_valid                 = out_valid_ff;
   assign rsp_frame_time_us         = o_ft_ff;
   assign rsp_current_fps           = o_cur_ff;
   assign rsp_average_frame_time_us = o_aft_ff;
   assign rsp_average_fps           = o_afps_ff;
   assign rsp_min_fps               = o_min_ff;
   assign rsp_max_fps               = o_max_ff;
   assign rsp_sample_count          = o_cnt_ff;

   assign status.keep      = keep_ff;
   assign status.div_done  = div_done;
   assign status.walk_done = walk_done_ff;
   assign status.out_busy  = out_valid_ff && !rsp_ready;

endmodule

>>> src/frws_ctrl.sv
// controller state machine sequencing window update, walk and divisions
module frws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  frws_pkg::status_type    status,
   output frws_pkg::cmd_type       cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_CHECK     = 11'b00000000010,
      S_WRITE     = 11'b00000000100,
      S_LAUNCH    = 11'b00000001000,
      S_DIV_AVG   = 11'b00000010000,
      S_DIV_CUR   = 11'b00000100000,
      S_DIV_AFPS  = 11'b00001000000,
      S_WAIT_WALK = 11'b00010000000,
      S_DIV_MIN   = 11'b00100000000,
      S_DIV_MAX   = 11'b01000000000,
      S_OUT       = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.keep) begin
               // fetch the entry about to be overwritten
               cmd.rd_old = 1'b1;
               state_in   = S_WRITE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WRITE: begin
            cmd.wr_win = 1'b1;
            state_in   = S_LAUNCH;
         end
         S_LAUNCH: begin
            cmd.walk_start = 1'b1;
            cmd.div_start  = 1'b1;
            cmd.div_sel    = frws_pkg::DSEL_AVG;
            state_in       = S_DIV_AVG;
         end
         S_DIV_AVG: begin
            if (status.div_done) begin
               cmd.cap_en    = 1'b1;
               cmd.cap_sel   = frws_pkg::DSEL_AVG;
               cmd.div_start = 1'b1;
               cmd.div_sel   = frws_pkg::DSEL_CUR;
               state_in      = S_DIV_CUR;
            end
         end
         S_DIV_CUR: begin
            if (status.div_done) begin
               cmd.cap_en    = 1'b1;
               cmd.cap_sel   = frws_pkg::DSEL_CUR;
               cmd.div_start = 1'b1;
               cmd.div_sel   = frws_pkg::DSEL_AFPS;
               state_in      = S_DIV_AFPS;
            end
         end
         S_DIV_AFPS: begin
            if (status.div_done) begin
               cmd.cap_en  = 1'b1;
               cmd.cap_sel = frws_pkg::DSEL_AFPS;
               if (status.walk_done) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = frws_pkg::DSEL_MIN;
                  state_in      = S_DIV_MIN;
               end else begin
                  state_in = S_WAIT_WALK;
               end
            end
         end
         S_WAIT_WALK: begin
            if (status.walk_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = frws_pkg::DSEL_MIN;
               state_in      = S_DIV_MIN;
            end
         end
         S_DIV_MIN: begin
            if (status.div_done) begin
               cmd.cap_en    = 1'b1;
               cmd.cap_sel   = frws_pkg::DSEL_MIN;
               cmd.div_start = 1'b1;
               cmd.div_sel   = frws_pkg::DSEL_MAX;
               state_in      = S_DIV_MAX;
            end
         end
         S_DIV_MAX: begin
            if (status.div_done) begin
               cmd.cap_en  = 1'b1;
               cmd.cap_sel = frws_pkg::DSEL_MAX;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            // wait for the output register to free up
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

>>> src/frws_checker.sv
// port-level checks of the frame rate window statistics block and their bind
`include "assert_macros.svh"

module frws_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [frws_pkg::IV_W-1:0]     rsp_frame_time_us,
   input  logic [frws_pkg::FPS_W-1:0]    rsp_current_fps,
   input  logic [frws_pkg::CNT_W-1:0]    rsp_sample_count
);

   logic                         seen_ff, seen_in;
   logic [frws_pkg::CNT_W-1:0]   last_cnt_ff, last_cnt_in;

   // count of the last item taken from the result side
   always_comb begin
      seen_in     = seen_ff;
      last_cnt_in = last_cnt_ff;
      if (rsp_valid && rsp_ready) begin
         seen_in     = 1'b1;
         last_cnt_in = rsp_sample_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         last_cnt_ff <= '0;
      end else begin
         seen_ff     <= seen_in;
         last_cnt_ff <= last_cnt_in;
      end
   end

   `FRWS_ASSERT_NEXT(busy_after_take, req_valid && req_ready, !req_ready, "ready held after take")

   `FRWS_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_time_us) && $stable(rsp_current_fps) && $stable(rsp_sample_count), "stalled result changed")

   `FRWS_ASSERT(count_range, rsp_valid |-> (rsp_sample_count != '0) && (rsp_sample_count <= frws_pkg::CNT_W'(frws_pkg::WINDOW_DEPTH)), "sample count out of range")

   `FRWS_ASSERT(count_steps, rsp_valid && seen_ff |-> (rsp_sample_count == last_cnt_ff + frws_pkg::CNT_W'(1)) || ((rsp_sample_count == last_cnt_ff) && (last_cnt_ff == frws_pkg::CNT_W'(frws_pkg::WINDOW_DEPTH))), "sample count skipped")

endmodule

bind frame_rate_window_stats frws_checker u_frws_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_frame_time_us (rsp_ch.frame_time_us),
   .rsp_current_fps   (rsp_ch.current_fps),
   .rsp_sample_count  (rsp_ch.sample_count)
);

>>> tb/tb_frame_rate_window_stats.sv
// testbench for the frame rate window statistics block: directed table, then random phases
module tb_frame_rate_window_stats;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [frws_pkg::IV_W-1:0]  frame_time_us;
      logic [frws_pkg::FPS_W-1:0] current_fps;
      logic [frws_pkg::IV_W-1:0]  average_frame_time_us;
      logic [frws_pkg::FPS_W-1:0] average_fps;
      logic [frws_pkg::FPS_W-1:0] min_fps;
      logic [frws_pkg::FPS_W-1:0] max_fps;
      logic [frws_pkg::CNT_W-1:0] sample_count;
   } frame_stats_type;

   typedef enum logic [1:0] {
      STEP_FRAME,
      STEP_SET_MIN,
      STEP_SET_MAX
   } step_kind_type;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_GIVEN,
      CHK_SILENT
   } check_type;

   typedef enum int {
      BOUNDS_RESET,
      BOUNDS_WIDEST,
      BOUNDS_ZERO,
      BOUNDS_FIELD_MAX,
      BOUNDS_NARROW,
      BOUNDS_SHORT,
      BOUNDS_CROSSED,
      BOUNDS_EQUAL
   } bound_mode_type;

   typedef struct packed {
      step_kind_type   kind;
      logic [31:0]     value;
      check_type       how;
      frame_stats_type given;
   } directed_step_type;

   localparam frame_stats_type NO_STATS = '0;
   localparam int NUM_STEPS = 25;
   localparam int RANDOM_ITEMS = 1130;

   localparam directed_step_type STEPS [NUM_STEPS] = '{
      '{STEP_FRAME,   32'd0,          CHK_SILENT, NO_STATS},  // primes, zero is ordinary
      '{STEP_FRAME,   32'd1000,       CHK_GIVEN,
        '{20'd1000, 28'd256000, 20'd1000, 28'd256000, 28'd256000, 28'd256000, 7'd1}},
      '{STEP_FRAME,   32'd1999,       CHK_SILENT, NO_STATS},  // one below min
      '{STEP_FRAME,   32'd1001999,    CHK_MODEL,  NO_STATS},  // exactly max
      '{STEP_FRAME,   32'd2002000,    CHK_SILENT, NO_STATS},  // one above max
      '{STEP_FRAME,   32'hFFFF_FC18,  CHK_SILENT, NO_STATS},
      '{STEP_FRAME,   32'h0000_0000,  CHK_MODEL,  NO_STATS},  // wraps to 1000
      '{STEP_FRAME,   32'hFFFF_FFFF,  CHK_SILENT, NO_STATS},
      '{STEP_SET_MIN, 32'hABC0_0001,  CHK_MODEL,  NO_STATS},  // upper bits dropped
      '{STEP_SET_MAX, 32'd1000000,    CHK_MODEL,  NO_STATS},
      '{STEP_FRAME,   32'h0000_0000,  CHK_MODEL,  NO_STATS},  // interval of 1
      '{STEP_FRAME,   32'd1000000,    CHK_MODEL,  NO_STATS},
      '{STEP_SET_MAX, 32'h5A5F_FFFF,  CHK_MODEL,  NO_STATS},
      '{STEP_FRAME,   32'd2048575,    CHK_MODEL,  NO_STATS},  // widest interval
      '{STEP_SET_MIN, 32'd0,          CHK_MODEL,  NO_STATS},
      '{STEP_SET_MAX, 32'd0,          CHK_MODEL,  NO_STATS},
      '{STEP_FRAME,   32'd2048575,    CHK_MODEL,  NO_STATS},  // zero interval, zero divisor
      '{STEP_FRAME,   32'd2048576,    CHK_SILENT, NO_STATS},
      '{STEP_SET_MIN, 32'd5000,       CHK_MODEL,  NO_STATS},  // bounds crossed
      '{STEP_SET_MAX, 32'd4000,       CHK_MODEL,  NO_STATS},
      '{STEP_FRAME,   32'd2053076,    CHK_SILENT, NO_STATS},
      '{STEP_FRAME,   32'd2058076,    CHK_SILENT, NO_STATS},
      '{STEP_FRAME,   32'd2062076,    CHK_SILENT, NO_STATS},
      '{STEP_SET_MIN, 32'hFFF0_03E8,  CHK_MODEL,  NO_STATS},
      '{STEP_SET_MAX, 32'd1000000,    CHK_MODEL,  NO_STATS}
   };

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [frws_pkg::CSR_AW-1:0] csr_paddr;
   logic [frws_pkg::CSR_DW-1:0] csr_pwdata;
   logic [frws_pkg::CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   frws_req_if req_if();
   frws_rsp_if rsp_if();

   frame_rate_window_stats DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [frws_pkg::IV_W-1:0]  lower_bound = frws_pkg::MIN_IV_RESET;
   logic [frws_pkg::IV_W-1:0]  upper_bound = frws_pkg::MAX_IV_RESET;
   logic [frws_pkg::TS_W-1:0]  prev_ts = '0;
   bit                         primed = 1'b0;
   logic [frws_pkg::IV_W-1:0]  intervals [frws_pkg::WINDOW_DEPTH];
   int unsigned                slot = 0;
   int unsigned                held = 0;
   logic [frws_pkg::SUM_W-1:0] total = '0;

   frame_stats_type pending_stats [$];
   int failures = 0;
   bit steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("frame_rate_window_stats: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      failures++;
      if (failures <= 40)
         $display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic logic [frws_pkg::FPS_W-1:0] fps_for(
      input logic [frws_pkg::IV_W-1:0] us);
      if (us == '0)
         return '0;
      return frws_pkg::FPS_SCALE / us;
   endfunction

   // returns 1 when the frame yields a statistics item
   function automatic bit predict_frame(input logic [frws_pkg::TS_W-1:0] ts,
                                        output frame_stats_type stats);
      logic [frws_pkg::TS_W-1:0] span;
      logic [frws_pkg::IV_W-1:0] shortest, longest, mean;
      stats = '0;
      if (!primed) begin
         primed = 1'b1;
         prev_ts = ts;
         return 1'b0;
      end
      span = ts - prev_ts;
      prev_ts = ts;
      if (span < frws_pkg::TS_W'(lower_bound) || span > frws_pkg::TS_W'(upper_bound))
         return 1'b0;
      if (held == frws_pkg::WINDOW_DEPTH)
         total -= intervals[slot];
      else
         held++;
      intervals[slot] = span[frws_pkg::IV_W-1:0];
      total += span[frws_pkg::IV_W-1:0];
      slot = (slot + 1) % frws_pkg::WINDOW_DEPTH;
      shortest = intervals[0];
      longest = intervals[0];
      for (int i = 1; i < held; i++) begin
         if (intervals[i] < shortest)
            shortest = intervals[i];
         if (intervals[i] > longest)
            longest = intervals[i];
      end
      mean = frws_pkg::IV_W'(total / held);
      stats.frame_time_us = span[frws_pkg::IV_W-1:0];
      stats.current_fps = fps_for(span[frws_pkg::IV_W-1:0]);
      stats.average_frame_time_us = mean;
      stats.average_fps = fps_for(mean);
      stats.min_fps = fps_for(longest);
      stats.max_fps = fps_for(shortest);
      stats.sample_count = frws_pkg::CNT_W'(held);
      return 1'b1;
   endfunction

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return $urandom_range(1, 2);
      else if (r < 92)
         return $urandom_range(3, 8);
      else if (r < 98)
         return $urandom_range(9, 30);
      return $urandom_range(40, 120);
   endfunction

   function automatic logic [frws_pkg::TS_W-1:0] next_timestamp(
      input logic [frws_pkg::TS_W-1:0] prev,
      input logic [frws_pkg::IV_W-1:0] lo,
      input logic [frws_pkg::IV_W-1:0] hi);
      int r;
      logic [frws_pkg::TS_W-1:0] step;
      r = $urandom_range(0, 99);
      if (r < 3)
         return $urandom;
      if (r < 70)
         step = $urandom_range(lo, hi);
      else if (r < 78)
         step = frws_pkg::TS_W'(lo);
      else if (r < 86)
         step = frws_pkg::TS_W'(hi);
      else if (r < 90)
         step = frws_pkg::TS_W'(lo) - 1;
      else if (r < 94)
         step = frws_pkg::TS_W'(hi) + 1;
      else if (r < 97)
         step = '0;
      else
         step = $urandom;
      return prev + step;
   endfunction

   task automatic send_frame(input logic [frws_pkg::TS_W-1:0] ts, input check_type how,
                             input frame_stats_type given);
      int idle;
      frame_stats_type stats;
      idle = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (idle > 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.timestamp_us <= ts;
      do @(posedge clock); while (!req_if.ready);
      if (predict_frame(ts, stats) && how != CHK_SILENT)
         pending_stats.insert(pending_stats.size(), how == CHK_GIVEN ? given : stats);
   endtask

   // priming and rejected items leave the block busy without giving a result
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic program_bound(input logic idx, input logic [frws_pkg::CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == frws_pkg::CSR_IDX_MIN)
         lower_bound = data[frws_pkg::IV_W-1:0];
      else
         upper_bound = data[frws_pkg::IV_W-1:0];
      // read back
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== frws_pkg::CSR_DW'(data[frws_pkg::IV_W-1:0]))
         report_mismatch(idx == frws_pkg::CSR_IDX_MIN ? "min_interval_us readback"
                                                      : "max_interval_us readback",
                         csr_prdata, data[frws_pkg::IV_W-1:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : result_stall
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0 && !steady && $urandom_range(0, 2) == 0)
            hold = idle_length();
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      frame_stats_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.frame_time_us, rsp_if.current_fps, rsp_if.average_frame_time_us,
                 rsp_if.average_fps, rsp_if.min_fps, rsp_if.max_fps, rsp_if.sample_count};
         if (pending_stats.size() == 0) begin
            report_mismatch("item with nothing pending, frame_time_us",
                            got.frame_time_us, 0);
         end else begin
            want = pending_stats[0];
            pending_stats.delete(0);
            if (got.frame_time_us !== want.frame_time_us)
               report_mismatch("frame_time_us", got.frame_time_us, want.frame_time_us);
            if (got.current_fps !== want.current_fps)
               report_mismatch("current_fps", got.current_fps, want.current_fps);
            if (got.average_frame_time_us !== want.average_frame_time_us)
               report_mismatch("average_frame_time_us", got.average_frame_time_us,
                               want.average_frame_time_us);
            if (got.average_fps !== want.average_fps)
               report_mismatch("average_fps", got.average_fps, want.average_fps);
            if (got.min_fps !== want.min_fps)
               report_mismatch("min_fps", got.min_fps, want.min_fps);
            if (got.max_fps !== want.max_fps)
               report_mismatch("max_fps", got.max_fps, want.max_fps);
            if (got.sample_count !== want.sample_count)
               report_mismatch("sample_count", got.sample_count, want.sample_count);
         end
      end
   end

   initial begin : stimulus
      logic [frws_pkg::TS_W-1:0] stream_ts;
      logic [frws_pkg::IV_W-1:0] lo, hi;
      logic [11:0] junk;
      bound_mode_type mode;
      int random_items, phase, n, pause_at;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.timestamp_us <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stream_ts = '0;
      for (int s = 0; s < NUM_STEPS; s++) begin
         case (STEPS[s].kind)
            STEP_FRAME: begin
               send_frame(STEPS[s].value, STEPS[s].how, STEPS[s].given);
               stream_ts = STEPS[s].value;
            end
            STEP_SET_MIN: begin
               quiesce();
               program_bound(frws_pkg::CSR_IDX_MIN, STEPS[s].value);
            end
            default: begin
               quiesce();
               program_bound(frws_pkg::CSR_IDX_MAX, STEPS[s].value);
            end
         endcase
      end

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         mode = bound_mode_type'((phase < 8) ? phase : $urandom_range(0, 7));
         case (mode)
            BOUNDS_RESET: begin
               lo = frws_pkg::MIN_IV_RESET;
               hi = frws_pkg::MAX_IV_RESET;
            end
            BOUNDS_WIDEST: begin
               lo = 20'd1;
               hi = 20'd1000000;
            end
            BOUNDS_ZERO: begin
               lo = '0;
               hi = '0;
            end
            BOUNDS_FIELD_MAX: begin
               lo = 20'd1;
               hi = '1;
            end
            BOUNDS_NARROW: begin
               lo = frws_pkg::IV_W'($urandom_range(1, 50000));
               hi = frws_pkg::IV_W'(32'(lo) + $urandom_range(0, 50000));
            end
            BOUNDS_SHORT: begin
               lo = '0;
               hi = frws_pkg::IV_W'($urandom_range(0, 2000));
            end
            BOUNDS_CROSSED: begin
               hi = frws_pkg::IV_W'($urandom_range(1, 999999));
               lo = frws_pkg::IV_W'($urandom_range(32'(hi) + 1, 1000000));
            end
            default: begin
               lo = frws_pkg::IV_W'($urandom_range(1, 1000000));
               hi = lo;
            end
         endcase
         quiesce();
         junk = 12'($urandom);
         program_bound(frws_pkg::CSR_IDX_MIN, {junk, lo});
         junk = 12'($urandom);
         program_bound(frws_pkg::CSR_IDX_MAX, {junk, hi});
         steady = ($urandom_range(0, 3) == 0);
         // a zero run must outlast the window so the average reaches zero
         n = (mode == BOUNDS_ZERO) ? 100 : $urandom_range(50, 110);
         pause_at = (phase == 1 || $urandom_range(0, 2) == 0) ? n / 2 : -1;
         for (int k = 0; k < n; k++) begin
            if (k == pause_at)
               quiesce();
            stream_ts = next_timestamp(stream_ts, lo, hi);
            send_frame(stream_ts, CHK_MODEL, NO_STATS);
         end
         random_items += n;
         phase++;
      end

      req_if.valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("frame_rate_window_stats: match");
      else
         $display("frame_rate_window_stats: mismatch");
      $finish;
   end

endmodule
